>>> rtl/core/ubxfp_pkg.sv
package ubxfp_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'hB5;
	localparam logic [7:0] SYNC_SECOND  = 8'h62;
	localparam logic [7:0] PVT_CLASS    = 8'h01;
	localparam logic [7:0] PVT_ID       = 8'h07;
	localparam int         PVT_LENGTH   = 92;
	localparam logic [7:0] ACK_CLASS    = 8'h05;
	localparam logic [7:0] VALGET_CLASS = 8'h06;
	localparam logic [7:0] VALGET_ID    = 8'h8B;

	localparam logic [2:0] ST_NONE   = 3'd0;
	localparam logic [2:0] ST_PVT    = 3'd1;
	localparam logic [2:0] ST_ACK    = 3'd2;
	localparam logic [2:0] ST_VALGET = 3'd3;
	localparam logic [2:0] ST_ERROR  = 3'd4;

	localparam logic [1:0] REG_PVT_ENABLE    = 2'd0;
	localparam logic [1:0] REG_ACK_ENABLE    = 2'd1;
	localparam logic [1:0] REG_VALGET_ENABLE = 2'd2;

	localparam logic [3:0] PVT_LAST_INDEX    = 4'd14;
	localparam logic [3:0] VALGET_LAST_INDEX = 4'd1;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} field_size_t;

	// capture word (four payload bytes) that holds a reported field
	function automatic logic [3:0] field_word(input logic is_valget, input logic [3:0] idx);
		logic [3:0] w;
		w = 4'd0;
		if (is_valget) begin
			w = (idx == 4'd0) ? 4'd0 : 4'd1;
		end else begin
			case (idx) inside
				4'd0:           w = 4'd0;
				4'd1:           w = 4'd6;
				4'd2:           w = 4'd7;
				4'd3:           w = 4'd8;
				4'd4:           w = 4'd9;
				4'd5:           w = 4'd10;
				[4'd6:4'd8]:    w = 4'd5;
				[4'd9:4'd11]:   w = 4'd1;
				[4'd12:4'd14]:  w = 4'd2;
				default:        w = 4'd0;
			endcase
		end
		return w;
	endfunction

	// pick the field's bytes out of its capture word, zero extended
	function automatic logic [31:0] field_pick(input logic is_valget, input logic [3:0] idx,
			input logic [31:0] word);
		logic [1:0]  lane;
		field_size_t size;
		logic [31:0] shifted;
		logic [31:0] v;
		lane = 2'd0;
		size = SIZE_WORD;
		if (is_valget) begin
			size = (idx == 4'd0) ? SIZE_WORD : SIZE_BYTE;
		end else begin
			case (idx) inside
				[4'd0:4'd5]: size = SIZE_WORD;
				4'd6:  begin lane = 2'd0; size = SIZE_BYTE; end
				4'd7:  begin lane = 2'd1; size = SIZE_BYTE; end
				4'd8:  begin lane = 2'd3; size = SIZE_BYTE; end
				4'd9:  begin lane = 2'd0; size = SIZE_HALF; end
				4'd10: begin lane = 2'd2; size = SIZE_BYTE; end
				4'd11: begin lane = 2'd3; size = SIZE_BYTE; end
				4'd12: begin lane = 2'd0; size = SIZE_BYTE; end
				4'd13: begin lane = 2'd1; size = SIZE_BYTE; end
				4'd14: begin lane = 2'd2; size = SIZE_BYTE; end
				default: size = SIZE_WORD;
			endcase
		end
		shifted = word >> {lane, 3'b000};
		case (size)
			SIZE_BYTE: v = {24'd0, shifted[7:0]};
			SIZE_HALF: v = {16'd0, shifted[15:0]};
			default:   v = word;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/ubx_frame_parser_unit.sv
// channel  | direction | payload
// s_*      | in        | tdata[7:0] rx_byte
// m_*      | out       | tuser[2:0] status; tdata[3:0] field_index, [35:4] field_value;
//          |           | tlast last
// apb      | in/out    | 0x0 pvt_enable, 0x4 ack_enable, 0x8 valget_enable
//
// Outside a field run, one byte is taken per cycle while the output register is free
// or being drained. A byte ending a NAV-PVT frame yields 15 items, a VALGET frame 2:
// the first word is read from the dual-port capture memory into a register, then one
// item per cycle while the output is free; input is held until the run is out.
// arst_n clears the parse state at once and sets the enables; no memory clearing pass.
// A stall on m_tready holds the output register and, with it, the input side.
module ubx_frame_parser_unit #(
	parameter int MAX_PAYLOAD  = 256,
	parameter int HEAD_CAPTURE = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] field_index, [35:4] field_value, [39:36] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW         = $clog2(MAX_PAYLOAD + 1);
	localparam int HEAD_WORDS = (HEAD_CAPTURE + 3) / 4;
	localparam int AW         = $clog2(HEAD_WORDS);

	localparam logic [3:0] PH_SYNC1   = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_ID      = 4'd3;
	localparam logic [3:0] PH_LEN1    = 4'd4;
	localparam logic [3:0] PH_LEN2    = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CKA     = 4'd7;
	localparam logic [3:0] PH_CKB     = 4'd8;

	// configuration
	logic pvt_en_q, ack_en_q, valget_en_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvt_en_q    <= 1'b1;
			ack_en_q    <= 1'b1;
			valget_en_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				ubxfp_pkg::REG_PVT_ENABLE:    pvt_en_q    <= pwdata[0];
				ubxfp_pkg::REG_ACK_ENABLE:    ack_en_q    <= pwdata[0];
				ubxfp_pkg::REG_VALGET_ENABLE: valget_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ubxfp_pkg::REG_PVT_ENABLE:    prdata = {31'd0, pvt_en_q};
			ubxfp_pkg::REG_ACK_ENABLE:    prdata = {31'd0, ack_en_q};
			ubxfp_pkg::REG_VALGET_ENABLE: prdata = {31'd0, valget_en_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// parse state
	logic [3:0]    phase_q, phase_d;
	logic [7:0]    class_q, class_d;
	logic [7:0]    id_q, id_d;
	logic [7:0]    len_lo_q, len_lo_d;
	logic [LW-1:0] length_q, length_d;
	logic [LW-1:0] pos_q, pos_d;
	logic [7:0]    sum_a_q, sum_a_d;
	logic [7:0]    sum_b_q, sum_b_d;
	logic [7:0]    check_a_q, check_a_d;

	// output register and field run
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [3:0]  out_index_q;
	logic [31:0] out_value_q;
	logic        out_last_q;
	logic        run_active_q;
	logic        run_valget_q, run_valget_d;
	logic [3:0]  run_idx_q, run_idx_d;
	logic        run_last;

	logic        accept, out_free, run_load;
	logic [7:0]  b;
	logic [7:0]  add_a, add_b;
	logic [15:0] len16;
	logic [LW-1:0] pos_inc;
	logic        check_ok;
	logic        start_run, start_valget;
	logic [2:0]  one_status;
	logic [31:0] one_value;
	logic        mem_we;

	logic [31:0]   head_mem [HEAD_WORDS];
	logic [31:0]   rd_word_q;
	logic [AW-1:0] rd_addr;

	assign b        = s_tdata;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !run_active_q && out_free;
	assign accept   = s_tvalid && s_tready;
	assign run_load = run_active_q && out_free;
	assign run_last = run_valget_q ? (run_idx_q == ubxfp_pkg::VALGET_LAST_INDEX)
	                               : (run_idx_q == ubxfp_pkg::PVT_LAST_INDEX);

	assign add_a    = sum_a_q + b;
	assign add_b    = sum_b_q + add_a;
	assign len16    = {b, len_lo_q};
	assign pos_inc  = pos_q + LW'(1);
	assign check_ok = (check_a_q == sum_a_q) && (b == sum_b_q);

	always_comb begin
		phase_d      = phase_q;
		class_d      = class_q;
		id_d         = id_q;
		len_lo_d     = len_lo_q;
		length_d     = length_q;
		pos_d        = pos_q;
		sum_a_d      = sum_a_q;
		sum_b_d      = sum_b_q;
		check_a_d    = check_a_q;
		one_status   = ubxfp_pkg::ST_NONE;
		one_value    = 32'd0;
		start_run    = 1'b0;
		start_valget = 1'b0;
		mem_we       = 1'b0;
		case (phase_q)
			PH_SYNC1: begin
				if (b == ubxfp_pkg::SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (b == ubxfp_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
			end
			PH_CLASS: begin
				class_d = b;
				sum_a_d = b;
				sum_b_d = b;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = b;
				sum_a_d = add_a;
				sum_b_d = add_b;
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				len_lo_d = b;
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				phase_d  = PH_LEN2;
			end
			PH_LEN2: begin
				if (len16 > 16'(MAX_PAYLOAD)) begin
					one_status = ubxfp_pkg::ST_ERROR;
					phase_d    = PH_SYNC1;
					sum_a_d    = 8'd0;
					sum_b_d    = 8'd0;
					pos_d      = '0;
				end else begin
					sum_a_d  = add_a;
					sum_b_d  = add_b;
					length_d = LW'(len16);
					pos_d    = '0;
					phase_d  = (len16 != 16'd0) ? PH_PAYLOAD : PH_CKA;
				end
			end
			PH_PAYLOAD: begin
				mem_we  = (pos_q < LW'(HEAD_CAPTURE));
				pos_d   = pos_inc;
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (pos_inc >= length_q) phase_d = PH_CKA;
			end
			PH_CKA: begin
				check_a_d = b;
				phase_d   = PH_CKB;
			end
			PH_CKB: begin
				if (!check_ok) begin
					one_status = ubxfp_pkg::ST_ERROR;
				end else if (class_q == ubxfp_pkg::PVT_CLASS && id_q == ubxfp_pkg::PVT_ID &&
						length_q == LW'(ubxfp_pkg::PVT_LENGTH) && pvt_en_q) begin
					start_run = 1'b1;
				end else if (class_q == ubxfp_pkg::ACK_CLASS && ack_en_q &&
						length_q == LW'(2)) begin
					one_status = ubxfp_pkg::ST_ACK;
					one_value  = {24'd0, id_q};
				end else if (class_q == ubxfp_pkg::VALGET_CLASS &&
						id_q == ubxfp_pkg::VALGET_ID && valget_en_q &&
						length_q >= LW'(5)) begin
					start_run    = 1'b1;
					start_valget = 1'b1;
				end
				phase_d = PH_SYNC1;
				sum_a_d = 8'd0;
				sum_b_d = 8'd0;
				pos_d   = '0;
			end
			default: begin
				phase_d = PH_SYNC1;
				sum_a_d = 8'd0;
				sum_b_d = 8'd0;
				pos_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			class_q   <= 8'd0;
			id_q      <= 8'd0;
			len_lo_q  <= 8'd0;
			length_q  <= '0;
			pos_q     <= '0;
			sum_a_q   <= 8'd0;
			sum_b_q   <= 8'd0;
			check_a_q <= 8'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			class_q   <= class_d;
			id_q      <= id_d;
			len_lo_q  <= len_lo_d;
			length_q  <= length_d;
			pos_q     <= pos_d;
			sum_a_q   <= sum_a_d;
			sum_b_q   <= sum_b_d;
			check_a_q <= check_a_d;
		end
	end

	// capture memory: one byte lane written per payload byte among the first HEAD_CAPTURE, one word read per cycle
	always_comb begin
		run_idx_d    = run_idx_q;
		run_valget_d = run_valget_q;
		if (accept && start_run) begin
			run_idx_d    = 4'd0;
			run_valget_d = start_valget;
		end else if (run_load) begin
			run_idx_d = run_idx_q + 4'd1;
		end
	end

	assign rd_addr = AW'(ubxfp_pkg::field_word(run_valget_d, run_idx_d));

	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			head_mem[pos_q[AW+1:2]][{pos_q[1:0], 3'b000} +: 8] <= b;
		end
		rd_word_q <= head_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
			run_valget_q <= 1'b0;
			run_idx_q    <= 4'd0;
		end else begin
			run_valget_q <= run_valget_d;
			run_idx_q    <= run_idx_d;
			if (accept && start_run) begin
				run_active_q <= 1'b1;
			end else if (run_load && run_last) begin
				run_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !start_run) begin
			out_valid_q <= 1'b1;
		end else if (run_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !start_run) begin
			out_status_q <= one_status;
			out_index_q  <= 4'd0;
			out_value_q  <= one_value;
			out_last_q   <= 1'b1;
		end else if (run_load) begin
			out_status_q <= run_valget_q ? ubxfp_pkg::ST_VALGET : ubxfp_pkg::ST_PVT;
			out_index_q  <= run_idx_q;
			out_value_q  <= ubxfp_pkg::field_pick(run_valget_q, run_idx_q, rd_word_q);
			out_last_q   <= run_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'd0, out_value_q, out_index_q};
	assign m_tlast  = out_last_q;

	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> !s_tready)
		else $error("input taken during a field run");

	a_request_yields_output: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (m_tvalid || run_active_q))
		else $error("accepted byte produced no result");

	a_open_run_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |->
			(m_tuser == ubxfp_pkg::ST_PVT || m_tuser == ubxfp_pkg::ST_VALGET))
		else $error("multi-item run with wrong status");

	a_run_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> (run_idx_q <= ubxfp_pkg::PVT_LAST_INDEX))
		else $error("field run index out of range");

endmodule

>>> test/ubx_frame_parser_unit_tb.sv
`timescale 1ns / 1ps

module ubx_frame_parser_unit_tb;

	localparam int MAX_PAYLOAD  = 256;
	localparam int HEAD_CAPTURE = 48;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASES       = 5;
	localparam int PHASE_BYTES  = 25;

	localparam int NAV_FIELD_OFFSET [15] = '{0, 24, 28, 32, 36, 40, 20, 21, 23, 4, 6, 7, 8, 9, 10};
	localparam int NAV_FIELD_BYTES  [15] = '{4, 4, 4, 4, 4, 4, 1, 1, 1, 2, 1, 1, 1, 1, 1};

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  index;
		logic [31:0] value;
		logic        last;
	} field_item_t;

	typedef struct packed {
		logic [7:0]  rx;
		logic        typed;
		logic [2:0]  status;
		logic [31:0] value;
	} step_t;

	typedef enum logic [3:0] {
		HUNT_SYNC1,
		HUNT_SYNC2,
		GET_CLASS,
		GET_ID,
		GET_LEN_LO,
		GET_LEN_HI,
		GET_PAYLOAD,
		GET_CK_A,
		GET_CK_B
	} parse_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int gap_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	parse_step_t parse_at = HUNT_SYNC1;
	logic [7:0]  frame_class = 8'd0;
	logic [7:0]  frame_id = 8'd0;
	logic [15:0] frame_len = 16'd0;
	logic [15:0] payload_seen = 16'd0;
	logic [7:0]  sum_a = 8'd0;
	logic [7:0]  sum_b = 8'd0;
	logic [7:0]  check_a_rx = 8'd0;
	logic [7:0]  head_store [HEAD_CAPTURE];
	logic        en_pvt = 1'b1;
	logic        en_ack = 1'b1;
	logic        en_valget = 1'b1;

	field_item_t fresh_fields [$];
	field_item_t pending_fields [$];

	step_t directed_steps [28] = '{
		'{8'h00, 1'b1, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hFF, 1'b1, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hB5, 1'b1, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hB5, 1'b1, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hB5, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h62, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h05, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h01, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h02, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h06, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h01, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h0F, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h38, 1'b1, ubxfp_pkg::ST_ACK, 32'h0000_0001},
		'{8'hB5, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h62, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hFF, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hFF, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hFF, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'hFF, 1'b1, ubxfp_pkg::ST_ERROR, 32'd0},
		'{8'hB5, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h62, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h00, 1'b0, ubxfp_pkg::ST_NONE, 32'd0},
		'{8'h01, 1'b1, ubxfp_pkg::ST_ERROR, 32'd0}
	};

	ubx_frame_parser_unit #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.HEAD_CAPTURE(HEAD_CAPTURE)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void emit_field(input logic [2:0] st, input logic [3:0] idx,
			input logic [31:0] val, input logic fin);
		field_item_t it;
		it.status = st;
		it.index = idx;
		it.value = val;
		it.last = fin;
		fresh_fields.push_back(it);
	endfunction

	function automatic logic [31:0] head_field(input int at, input int n);
		logic [31:0] v;
		v = 32'd0;
		for (int i = 0; i < n; i++) begin
			if (at + i < HEAD_CAPTURE) begin
				v[8*i +: 8] = head_store[at + i];
			end
		end
		return v;
	endfunction

	function automatic void add_to_sums(input logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	function automatic void restart_hunt();
		parse_at = HUNT_SYNC1;
		sum_a = 8'd0;
		sum_b = 8'd0;
		payload_seen = 16'd0;
	endfunction

	function automatic void close_frame(input logic [7:0] check_b);
		if (check_a_rx != sum_a || check_b != sum_b) begin
			emit_field(ubxfp_pkg::ST_ERROR, 4'd0, 32'd0, 1'b1);
		end else if (frame_class == ubxfp_pkg::PVT_CLASS && frame_id == ubxfp_pkg::PVT_ID &&
				frame_len == ubxfp_pkg::PVT_LENGTH && en_pvt) begin
			for (int i = 0; i < 15; i++) begin
				emit_field(ubxfp_pkg::ST_PVT, 4'(i),
					head_field(NAV_FIELD_OFFSET[i], NAV_FIELD_BYTES[i]),
					4'(i) == ubxfp_pkg::PVT_LAST_INDEX);
			end
		end else if (frame_class == ubxfp_pkg::ACK_CLASS && en_ack && frame_len == 16'd2) begin
			emit_field(ubxfp_pkg::ST_ACK, 4'd0, {24'd0, frame_id}, 1'b1);
		end else if (frame_class == ubxfp_pkg::VALGET_CLASS &&
				frame_id == ubxfp_pkg::VALGET_ID && en_valget && frame_len >= 16'd5) begin
			emit_field(ubxfp_pkg::ST_VALGET, 4'd0, head_field(0, 4), 1'b0);
			emit_field(ubxfp_pkg::ST_VALGET, ubxfp_pkg::VALGET_LAST_INDEX,
				head_field(4, 1), 1'b1);
		end else begin
			emit_field(ubxfp_pkg::ST_NONE, 4'd0, 32'd0, 1'b1);
		end
		restart_hunt();
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		logic [15:0] full_len;
		fresh_fields.delete();
		case (parse_at)
			HUNT_SYNC1: begin
				if (b == ubxfp_pkg::SYNC_FIRST) parse_at = HUNT_SYNC2;
			end
			HUNT_SYNC2: begin
				parse_at = (b == ubxfp_pkg::SYNC_SECOND) ? GET_CLASS : HUNT_SYNC1;
			end
			GET_CLASS: begin
				frame_class = b;
				sum_a = 8'd0;
				sum_b = 8'd0;
				add_to_sums(b);
				parse_at = GET_ID;
			end
			GET_ID: begin
				frame_id = b;
				add_to_sums(b);
				parse_at = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				frame_len = {8'd0, b};
				add_to_sums(b);
				parse_at = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				full_len = {b, frame_len[7:0]};
				add_to_sums(b);
				if (full_len > 16'(MAX_PAYLOAD)) begin
					emit_field(ubxfp_pkg::ST_ERROR, 4'd0, 32'd0, 1'b1);
					restart_hunt();
				end else begin
					frame_len = full_len;
					payload_seen = 16'd0;
					parse_at = (full_len != 16'd0) ? GET_PAYLOAD : GET_CK_A;
				end
			end
			GET_PAYLOAD: begin
				if (payload_seen < 16'(HEAD_CAPTURE)) head_store[payload_seen] = b;
				payload_seen = payload_seen + 16'd1;
				add_to_sums(b);
				if (payload_seen >= frame_len) parse_at = GET_CK_A;
			end
			GET_CK_A: begin
				check_a_rx = b;
				parse_at = GET_CK_B;
			end
			GET_CK_B: begin
				close_frame(b);
			end
			default: begin
				restart_hunt();
			end
		endcase
		if (fresh_fields.size() == 0) emit_field(ubxfp_pkg::ST_NONE, 4'd0, 32'd0, 1'b1);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] st,
			input logic [31:0] val);
		field_item_t it;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b);
		if (typed) begin
			it.status = st;
			it.index = 4'd0;
			it.value = val;
			it.last = 1'b1;
			pending_fields.push_back(it);
		end else begin
			foreach (fresh_fields[i]) pending_fields.push_back(fresh_fields[i]);
		end
		bytes_sent++;
	endtask

	// drop valid and hold until every expected item has come out
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0) @(posedge clk);
	endtask

	task automatic program_enables(input logic pvt, input logic ack, input logic valget);
		logic [1:0] sel [3];
		logic       val [3];
		sel[0] = ubxfp_pkg::REG_PVT_ENABLE;
		sel[1] = ubxfp_pkg::REG_ACK_ENABLE;
		sel[2] = ubxfp_pkg::REG_VALGET_ENABLE;
		val[0] = pvt;
		val[1] = ack;
		val[2] = valget;
		for (int i = 0; i < 3; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {sel[i], 2'b00};
			pwdata <= {31'($urandom), val[i]};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			case (sel[i])
				ubxfp_pkg::REG_PVT_ENABLE:    en_pvt = val[i];
				ubxfp_pkg::REG_ACK_ENABLE:    en_ack = val[i];
				ubxfp_pkg::REG_VALGET_ENABLE: en_valget = val[i];
				default: ;
			endcase
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
			input logic bad_check, input int cut);
		logic [7:0] wire_q [$];
		logic [7:0] ca;
		logic [7:0] cb;
		int         pay;
		int         n;
		pay = (len <= MAX_PAYLOAD) ? len : 0;
		wire_q.push_back(ubxfp_pkg::SYNC_FIRST);
		wire_q.push_back(ubxfp_pkg::SYNC_SECOND);
		wire_q.push_back(cls);
		wire_q.push_back(id);
		wire_q.push_back(len[7:0]);
		wire_q.push_back(len[15:8]);
		for (int i = 0; i < pay; i++) wire_q.push_back(8'($urandom));
		ca = 8'd0;
		cb = 8'd0;
		for (int i = 2; i < wire_q.size(); i++) begin
			ca = ca + wire_q[i];
			cb = cb + ca;
		end
		if (bad_check) begin
			if ($urandom_range(1) == 0) ca = ca ^ 8'(1 << $urandom_range(7));
			else cb = cb ^ 8'(1 << $urandom_range(7));
		end
		wire_q.push_back(ca);
		wire_q.push_back(cb);
		n = (cut < 0 || cut > wire_q.size()) ? wire_q.size() : cut;
		for (int i = 0; i < n; i++) send_byte(wire_q[i], 1'b0, ubxfp_pkg::ST_NONE, 32'd0);
	endtask

	task automatic send_noise(input int count);
		logic [7:0] b;
		for (int i = 0; i < count; i++) begin
			b = ($urandom_range(3) == 0) ? ubxfp_pkg::SYNC_FIRST : 8'($urandom);
			send_byte(b, 1'b0, ubxfp_pkg::ST_NONE, 32'd0);
		end
	endtask

	task automatic send_mixed_frame();
		int   pick;
		int   len;
		logic bad;
		pick = $urandom_range(99);
		bad = ($urandom_range(99) < 15);
		if (pick < 20) begin
			len = ($urandom_range(9) == 0) ? 91 + 2 * $urandom_range(1)
			                               : ubxfp_pkg::PVT_LENGTH;
			send_frame(ubxfp_pkg::PVT_CLASS, ubxfp_pkg::PVT_ID, len, bad, -1);
		end else if (pick < 38) begin
			len = ($urandom_range(6) == 0) ? $urandom_range(3) : 2;
			send_frame(ubxfp_pkg::ACK_CLASS, 8'($urandom), len, bad, -1);
		end else if (pick < 55) begin
			case ($urandom_range(9))
				0:       len = MAX_PAYLOAD;
				1:       len = 4;
				default: len = $urandom_range(12, 5);
			endcase
			send_frame(ubxfp_pkg::VALGET_CLASS, ubxfp_pkg::VALGET_ID, len, bad, -1);
		end else if (pick < 68) begin
			send_frame(8'($urandom), 8'($urandom), $urandom_range(8), bad, -1);
		end else if (pick < 77) begin
			case ($urandom_range(3))
				0:       len = MAX_PAYLOAD + 1;
				1:       len = 65535;
				default: len = $urandom_range(65535, MAX_PAYLOAD + 1);
			endcase
			send_frame(8'($urandom), 8'($urandom), len, 1'b0, 6);
		end else if (pick < 84) begin
			send_frame(8'($urandom), 8'($urandom), $urandom_range(8), 1'b0,
				$urandom_range(5, 2));
			send_noise($urandom_range(4, 1));
		end else begin
			send_noise($urandom_range(6, 1));
		end
	endtask

	always @(posedge clk) begin
		field_item_t got;
		field_item_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.index = m_tdata[3:0];
				got.value = m_tdata[35:4];
				got.last = m_tlast;
				if (pending_fields.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected item: status %0d index %0d value %08h last %0b",
							got.status, got.index, got.value, got.last);
					end
				end else begin
					want = pending_fields.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("mismatch: status %0d/%0d index %0d/%0d value %08h/%08h last %0b/%0b (exp/got)",
								want.status, got.status, want.index, got.index,
								want.value, got.value, want.last, got.last);
						end
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[k]) begin
			send_byte(directed_steps[k].rx, directed_steps[k].typed, directed_steps[k].status,
				directed_steps[k].value);
		end
		hold_until_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 75; stall_pct = 0;  program_enables(1'b1, 1'b0, 1'b1); end
				2: begin gap_pct = 0;  stall_pct = 75; program_enables(1'b1, 1'b1, 1'b0); end
				3: begin gap_pct = 14; stall_pct = 14; program_enables(1'b0, 1'b0, 1'b0); end
				default: begin gap_pct = 14; stall_pct = 14; program_enables(1'b1, 1'b1, 1'b1); end
			endcase
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				send_mixed_frame();
				if ($urandom_range(99) < 8) hold_until_drained();
			end
			hold_until_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/ubxfp_pkg.sv
rtl/core/ubx_frame_parser_unit.sv
test/ubx_frame_parser_unit_tb.sv
